// ===== hdl/hsvrgb_pkg.sv =====
// Shared types and constants for the HSV to RGB converter pipeline.
// No dependencies; used by every module of the block.
package hsvrgb_pkg;

	// Fixed point: 65536 is 1.0 for saturation and value
	localparam int unsigned ONE_Q16  = 65536;
	localparam int unsigned SECTORS  = 6;
	localparam int unsigned CHAN_MAX = 255;

	// Widths of the stream fields
	localparam int HUE_W  = 32;
	localparam int FRAC_W = 16;
	localparam int SV_W   = 18;
	localparam int CHAN_W = 8;

	// Internal widths
	localparam int UNIT_W  = FRAC_W + 1;        // 0..65536
	localparam int W_W     = 24;                // 255 * V, at most 0xFF0000
	localparam int INNER_W = 2 * FRAC_W + 1;    // 2^32 - S*k, 0..2^32
	localparam int PP_W    = W_W + FRAC_W;      // 255 * V * (65536 - S)
	localparam int PQ_W    = W_W + 2 * FRAC_W;  // 255 * V * inner

	// Hue sectors, one per sixth of a turn
	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	// Decoded pixel leaving the front stage
	typedef struct packed {
		logic                err;
		sector_t             sector;
		logic [FRAC_W-1:0]   f;
		logic [UNIT_W-1:0]   fc;
		logic [UNIT_W-1:0]   s;
		logic [UNIT_W-1:0]   sp;
		logic [W_W-1:0]      w;
	} front_t;

	// Scaled levels leaving the multiplier stages
	typedef struct packed {
		logic                err;
		sector_t             sector;
		logic [W_W-1:0]      w;
		logic [PP_W-1:0]     pp;
		logic [PQ_W-1:0]     pq;
		logic [PQ_W-1:0]     pt;
	} level_t;

endpackage

// ===== hdl/hsvrgb_front.sv =====
// First pipeline stage: range check, hue sector and fraction, 255*V.
// Depends on hsvrgb_pkg.
module hsvrgb_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [hsvrgb_pkg::FRAC_W-1:0]     hue_frac,
	input  logic signed [hsvrgb_pkg::SV_W-1:0] saturation,
	input  logic signed [hsvrgb_pkg::SV_W-1:0] brightness,
	output logic                              out_valid,
	input  logic                              out_ready,
	output hsvrgb_pkg::front_t                out
);

	localparam int FW = hsvrgb_pkg::FRAC_W;
	localparam int UW = hsvrgb_pkg::UNIT_W;

	logic                   valid_s1;
	hsvrgb_pkg::front_t     data_s1;
	hsvrgb_pkg::front_t     data_d;
	logic [FW+2:0]          prod6;
	logic [UW-1:0]          s_mag;
	logic [UW-1:0]          v_mag;
	logic                   s_bad;
	logic                   v_bad;
	logic                   adv;

	// Out of range: negative, or above 1.0
	assign s_mag = saturation[UW-1:0];
	assign v_mag = brightness[UW-1:0];
	assign s_bad = saturation[hsvrgb_pkg::SV_W-1] | (s_mag[UW-1] & (|s_mag[FW-1:0]));
	assign v_bad = brightness[hsvrgb_pkg::SV_W-1] | (v_mag[UW-1] & (|v_mag[FW-1:0]));

	// Six times the hue fraction: sector on top, fraction below
	assign prod6 = {1'b0, hue_frac, 2'b00} + {2'b00, hue_frac, 1'b0};

	always_comb begin
		data_d.err    = s_bad | v_bad;
		data_d.sector = hsvrgb_pkg::sector_t'(prod6[FW+2:FW]);
		data_d.f      = prod6[FW-1:0];
		data_d.fc     = UW'(hsvrgb_pkg::ONE_Q16) - {1'b0, prod6[FW-1:0]};
		data_d.s      = s_mag;
		data_d.sp     = UW'(hsvrgb_pkg::ONE_Q16) - s_mag;
		data_d.w      = {v_mag[hsvrgb_pkg::W_W-9:0], 8'b0} - hsvrgb_pkg::W_W'(v_mag);
	end

	// Advance when the stage is empty or its transaction moves on
	assign adv       = ~valid_s1 | out_ready;
	assign in_ready  = adv;
	assign out_valid = valid_s1;
	assign out       = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			data_s1 <= data_d;
		end
	end

endmodule

// ===== hdl/hsvrgb_mul.sv =====
// Stages two to four: S*f products, 2^32 - S*k, then 255*V times each level.
// Depends on hsvrgb_pkg.
module hsvrgb_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  hsvrgb_pkg::front_t in,
	output logic               out_valid,
	input  logic               out_ready,
	output hsvrgb_pkg::level_t out
);

	localparam int FW = hsvrgb_pkg::FRAC_W;
	localparam int IW = hsvrgb_pkg::INNER_W;
	localparam int WW = hsvrgb_pkg::W_W;
	localparam int PW = hsvrgb_pkg::PP_W;
	localparam int QW = hsvrgb_pkg::PQ_W;
	localparam logic [IW-1:0] FULL = {1'b1, {(IW-1){1'b0}}};

	// Stage two registers
	logic                   valid_s2;
	logic                   err_s2;
	hsvrgb_pkg::sector_t    sector_s2;
	logic [WW-1:0]          w_s2;
	logic [PW-1:0]          pp_s2;
	logic [IW-1:0]          sf_s2;
	logic [IW-1:0]          sfc_s2;
	// Stage three registers
	logic                   valid_s3;
	logic                   err_s3;
	hsvrgb_pkg::sector_t    sector_s3;
	logic [WW-1:0]          w_s3;
	logic [PW-1:0]          pp_s3;
	logic [IW-1:0]          iq_s3;
	logic [IW-1:0]          it_s3;
	// Stage four registers
	logic                   valid_s4;
	hsvrgb_pkg::level_t     lvl_s4;

	logic                   adv2;
	logic                   adv3;
	logic                   adv4;
	logic [QW-1:0]          pq_d;
	logic [QW-1:0]          pt_d;

	// Stall chain: a stage takes new data when empty or draining
	assign adv4     = ~valid_s4 | out_ready;
	assign adv3     = ~valid_s3 | adv4;
	assign adv2     = ~valid_s2 | adv3;
	assign in_ready = adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv2) begin
				valid_s2 <= in_valid;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
			if (adv4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// Stage two: S*f, S*(1-f) and 255*V*(1-S)
	always_ff @(posedge clk) begin
		if (adv2 && in_valid) begin
			err_s2    <= in.err;
			sector_s2 <= in.sector;
			w_s2      <= in.w;
			sf_s2     <= IW'(in.s) * IW'(in.f);
			sfc_s2    <= IW'(in.s) * IW'(in.fc);
			pp_s2     <= PW'(in.w) * PW'(in.sp);
		end
	end

	// Stage three: inner terms 2^32 - S*k
	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			err_s3    <= err_s2;
			sector_s3 <= sector_s2;
			w_s3      <= w_s2;
			pp_s3     <= pp_s2;
			iq_s3     <= FULL - sf_s2;
			it_s3     <= FULL - sfc_s2;
		end
	end

	// Stage four: 255*V times inner; inner reaches 2^32 only with zero low bits
	assign pq_d = iq_s3[IW-1] ? {w_s3, {(2*FW){1'b0}}} : QW'(w_s3) * QW'(iq_s3[IW-2:0]);
	assign pt_d = it_s3[IW-1] ? {w_s3, {(2*FW){1'b0}}} : QW'(w_s3) * QW'(it_s3[IW-2:0]);

	always_ff @(posedge clk) begin
		if (adv4 && valid_s3) begin
			lvl_s4.err    <= err_s3;
			lvl_s4.sector <= sector_s3;
			lvl_s4.w      <= w_s3;
			lvl_s4.pp     <= pp_s3;
			lvl_s4.pq     <= pq_d;
			lvl_s4.pt     <= pt_d;
		end
	end

	assign out_valid = valid_s4;
	assign out       = lvl_s4;

endmodule

// ===== hdl/hsvrgb_select.sv =====
// Final stage: take the channel levels and route them by hue sector.
// Depends on hsvrgb_pkg.
module hsvrgb_select (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  hsvrgb_pkg::level_t              in,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [hsvrgb_pkg::CHAN_W-1:0]   red,
	output logic [hsvrgb_pkg::CHAN_W-1:0]   green,
	output logic [hsvrgb_pkg::CHAN_W-1:0]   blue,
	output logic                            range_error
);

	localparam int CW = hsvrgb_pkg::CHAN_W;
	localparam int WW = hsvrgb_pkg::W_W;
	localparam int PW = hsvrgb_pkg::PP_W;
	localparam int QW = hsvrgb_pkg::PQ_W;

	logic            valid_s5;
	logic [CW-1:0]   red_s5;
	logic [CW-1:0]   green_s5;
	logic [CW-1:0]   blue_s5;
	logic            err_s5;
	logic [CW-1:0]   cv;
	logic [CW-1:0]   cp;
	logic [CW-1:0]   cq;
	logic [CW-1:0]   ct;
	logic [CW-1:0]   r_d;
	logic [CW-1:0]   g_d;
	logic [CW-1:0]   b_d;
	logic            adv;

	// Floor of each level: drop the fraction bits
	assign cv = in.w[WW-1:WW-CW];
	assign cp = in.pp[PW-1:PW-CW];
	assign cq = in.pq[QW-1:QW-CW];
	assign ct = in.pt[QW-1:QW-CW];

	// Route levels by sector; a range error blanks the color
	always_comb begin
		case (in.sector)
			hsvrgb_pkg::SEC_RED_YEL: begin r_d = cv; g_d = ct; b_d = cp; end
			hsvrgb_pkg::SEC_YEL_GRN: begin r_d = cq; g_d = cv; b_d = cp; end
			hsvrgb_pkg::SEC_GRN_CYN: begin r_d = cp; g_d = cv; b_d = ct; end
			hsvrgb_pkg::SEC_CYN_BLU: begin r_d = cp; g_d = cq; b_d = cv; end
			hsvrgb_pkg::SEC_BLU_MAG: begin r_d = ct; g_d = cp; b_d = cv; end
			default: begin r_d = cv; g_d = cp; b_d = cq; end
		endcase
		if (in.err) begin
			r_d = '0;
			g_d = '0;
			b_d = '0;
		end
	end

	// Output register: hold while the result waits
	assign adv      = ~valid_s5 | out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			red_s5   <= r_d;
			green_s5 <= g_d;
			blue_s5  <= b_d;
			err_s5   <= in.err;
		end
	end

	assign out_valid   = valid_s5;
	assign red         = red_s5;
	assign green       = green_s5;
	assign blue        = blue_s5;
	assign range_error = err_s5;

endmodule

// ===== hdl/hsv_to_rgb_converter_unit.sv =====
// HSV to RGB converter: one pixel per clock through a five-stage pipeline.
// Hue is signed Q15.16 turns (only the fraction bits count, so any hue wraps);
// saturation and value are signed Q.16 with 65536 as 1.0. Each channel is
// floor(level * 255). Saturation or value outside [0, 1.0] gives black with
// range_error set in tuser. A new transaction is taken every cycle unless
// the output stalls; the register stages are decode, two multiplier stages
// with a subtract stage between them, and sector select.
// Stalls at the output back up stage by stage, filling empty stages first.
// Depends on hsvrgb_pkg and the hsvrgb_* stage modules.
module hsv_to_rgb_converter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // hue[31:0], saturation[49:32], brightness[67:50], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // red[7:0], green[15:8], blue[23:16]
	output logic        m_tuser    // range_error[0]
);

	localparam int FW = hsvrgb_pkg::FRAC_W;
	localparam int SW = hsvrgb_pkg::SV_W;
	localparam int HW = hsvrgb_pkg::HUE_W;
	localparam int CW = hsvrgb_pkg::CHAN_W;

	logic               front_valid;
	logic               front_ready;
	hsvrgb_pkg::front_t front_data;
	logic               mul_valid;
	logic               mul_ready;
	hsvrgb_pkg::level_t mul_data;
	logic [CW-1:0]      red;
	logic [CW-1:0]      green;
	logic [CW-1:0]      blue;

	// Decode the incoming transaction
	hsvrgb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.hue_frac   (s_tdata[FW-1:0]),
		.saturation (s_tdata[HW+SW-1:HW]),
		.brightness (s_tdata[HW+2*SW-1:HW+SW]),
		.out_valid  (front_valid),
		.out_ready  (front_ready),
		.out        (front_data)
	);

	// Compute the scaled levels
	hsvrgb_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in        (front_data),
		.out_valid (mul_valid),
		.out_ready (mul_ready),
		.out       (mul_data)
	);

	// Select channels and hold the result
	hsvrgb_select u_select (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (mul_valid),
		.in_ready    (mul_ready),
		.in          (mul_data),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.range_error (m_tuser)
	);

	assign m_tdata = {blue, green, red};

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for hsv_to_rgb_converter_unit: streams HSV pixels in,
// predicts each RGB result in fixed point and compares it as it leaves the block.
// Depends on hsvrgb_pkg and the converter RTL.
module tb_top;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PRINT_CAP    = 40;
	localparam int CW = hsvrgb_pkg::CHAN_W;
	localparam int HW = hsvrgb_pkg::HUE_W;
	localparam int SW = hsvrgb_pkg::SV_W;
	localparam int FW = hsvrgb_pkg::FRAC_W;

	// Expected color of one pixel
	typedef struct {
		logic [CW-1:0] red;
		logic [CW-1:0] green;
		logic [CW-1:0] blue;
		logic          range_error;
	} pixel_rgb_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;   // hue[31:0], saturation[49:32], brightness[67:50], zero pad
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // red[7:0], green[15:8], blue[23:16]
	logic        m_tuser;        // range_error[0]

	pixel_rgb_t rgb_expected[$];
	pixel_rgb_t want;
	int unsigned cycles = 0;
	int unsigned mismatches = 0;
	int unsigned pixels_sent = 0;
	int unsigned pixels_bad_range = 0;
	int unsigned results_checked = 0;
	int unsigned input_stalls = 0;
	bit tx_gaps = 1'b0;
	bit rx_gaps = 1'b0;
	int hold_req = 0;
	int hold_left = 0;
	int rx_gap_left = 0;

	hsv_to_rgb_converter_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// floor(255 * V * (2^32 - S*k) / 2^48), exact in 64 bits
	function automatic logic [CW-1:0] scaled_level(input longint unsigned v,
			input longint unsigned s, input longint unsigned k);
		longint unsigned inner;
		longint unsigned prod;
		inner = (64'd1 << 32) - s * k;
		prod = v * inner * 64'(hsvrgb_pkg::CHAN_MAX);
		return prod[55:48];
	endfunction

	// Predict the RGB result of one HSV pixel
	function automatic pixel_rgb_t predict_color(input logic signed [HW-1:0] hue,
			input logic signed [SW-1:0] sat, input logic signed [SW-1:0] bri);
		pixel_rgb_t px;
		int s_val;
		int v_val;
		logic [18:0] hue6;
		hsvrgb_pkg::sector_t sec;
		longint unsigned frac;
		longint unsigned one;
		logic [CW-1:0] lv, lp, lq, lt;
		s_val = int'(sat);
		v_val = int'(bri);
		one = 64'(hsvrgb_pkg::ONE_Q16);
		px = '{default: '0};
		if (s_val < 0 || s_val > int'(hsvrgb_pkg::ONE_Q16) || v_val < 0 ||
				v_val > int'(hsvrgb_pkg::ONE_Q16)) begin
			px.range_error = 1'b1;
			return px;
		end
		hue6 = 19'(hue[FW-1:0]) * 19'(hsvrgb_pkg::SECTORS);
		sec = hsvrgb_pkg::sector_t'(hue6[18:16]);
		frac = 64'(hue6[15:0]);
		lv = scaled_level(64'(v_val), 64'(s_val), 64'd0);
		lp = scaled_level(64'(v_val), 64'(s_val), one);
		lq = scaled_level(64'(v_val), 64'(s_val), frac);
		lt = scaled_level(64'(v_val), 64'(s_val), one - frac);
		case (sec)
			hsvrgb_pkg::SEC_RED_YEL: begin px.red = lv; px.green = lt; px.blue = lp; end
			hsvrgb_pkg::SEC_YEL_GRN: begin px.red = lq; px.green = lv; px.blue = lp; end
			hsvrgb_pkg::SEC_GRN_CYN: begin px.red = lp; px.green = lv; px.blue = lt; end
			hsvrgb_pkg::SEC_CYN_BLU: begin px.red = lp; px.green = lq; px.blue = lv; end
			hsvrgb_pkg::SEC_BLU_MAG: begin px.red = lt; px.green = lp; px.blue = lv; end
			default: begin px.red = lv; px.green = lp; px.blue = lq; end
		endcase
		return px;
	endfunction

	// Count and print one mismatch, quietly once the print budget is spent
	task automatic report_mismatch(input string what, input int unsigned exp_val,
			input int unsigned got_val);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("MISMATCH result %0d: %s expected %0h got %0h",
				results_checked, what, exp_val, got_val);
	endtask

	// Offer one pixel, wait for the transaction, queue its expected color
	task automatic send_pixel(input logic [HW-1:0] hue, input logic [SW-1:0] sat,
			input logic [SW-1:0] bri);
		pixel_rgb_t px;
		s_tdata <= {4'b0, bri, sat, hue};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		px = predict_color(hue, sat, bri);
		rgb_expected.push_back(px);
		pixels_sent++;
		if (px.range_error)
			pixels_bad_range++;
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat (pick_gap()) @(posedge clk);
		end
	endtask

	// Drive ready: long hold-off on request, random gaps, otherwise accept
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (rx_gap_left > 0) begin
			m_tready <= 1'b0;
			rx_gap_left--;
		end else begin
			m_tready <= 1'b1;
			if (rx_gaps && $urandom_range(0, 4) == 0)
				rx_gap_left = pick_gap();
		end
	end

	// Check each output transaction against the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && !s_tready)
				input_stalls++;
			if (m_tvalid && m_tready) begin
				if (rgb_expected.size() == 0) begin
					report_mismatch("unexpected result, tdata", 0, 32'(m_tdata));
				end else begin
					want = rgb_expected.pop_front();
					if (m_tdata[7:0] !== want.red)
						report_mismatch("red", 32'(want.red), 32'(m_tdata[7:0]));
					if (m_tdata[15:8] !== want.green)
						report_mismatch("green", 32'(want.green), 32'(m_tdata[15:8]));
					if (m_tdata[23:16] !== want.blue)
						report_mismatch("blue", 32'(want.blue), 32'(m_tdata[23:16]));
					if (m_tuser !== want.range_error)
						report_mismatch("range_error", 32'(want.range_error),
							32'(m_tuser));
					results_checked++;
				end
			end
		end
	end

	// Watchdog
	initial begin
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycles,
			rgb_expected.size());
		$display("end of test: mismatches");
		$finish;
	end

	// Corners: sector centers, wrap, grey, range limits of both Q.16 inputs
	task automatic test_directed();
		logic [SW-1:0] one;
		one = SW'(hsvrgb_pkg::ONE_Q16);
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		send_pixel(32'd0, one, one);
		for (int k = 0; k < 6; k++)
			send_pixel(32'((2 * k + 1) * hsvrgb_pkg::ONE_Q16 / 12), one, one);
		send_pixel(32'hFFFF_FFFF, one, one);
		send_pixel(32'h8000_0000, one, one);
		send_pixel(32'h7FFF_FFFF, one, one);
		send_pixel(32'hFFFD_5555, 18'd40000, 18'd50000);
		send_pixel(32'd20000, 18'd0, one);
		send_pixel(32'd20000, 18'd0, 18'd32768);
		send_pixel(32'd20000, 18'd0, 18'd1);
		send_pixel(32'd30000, one, 18'd0);
		send_pixel(32'd1000, one + 18'd1, one);
		send_pixel(32'd1000, 18'h3FFFF, one);
		send_pixel(32'd1000, one, one + 18'd1);
		send_pixel(32'd1000, one, 18'h3FFFF);
		send_pixel(32'd1000, 18'h1FFFF, 18'd100);
		send_pixel(32'd1000, 18'h20000, 18'd100);
		send_pixel(32'd1000, 18'd100, 18'h1FFFF);
		send_pixel(32'd1000, 18'd100, 18'h20000);
		send_pixel(32'd10923, one, one);
		send_pixel(32'd65535, one, one);
	endtask

	// Level in [0, 1.0], biased toward the ends
	function automatic logic [SW-1:0] rand_level();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return SW'(hsvrgb_pkg::ONE_Q16);
			2: return SW'($urandom_range(0, 255));
			default: return SW'($urandom_range(0, hsvrgb_pkg::ONE_Q16));
		endcase
	endfunction

	// Random pixels with idle and stall on both sides
	task automatic test_random_traffic(input int count);
		logic [HW-1:0] hue;
		logic [SW-1:0] sat, bri;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		for (int i = 0; i < count; i++) begin
			hue = $urandom;
			if ($urandom_range(0, 4) == 0)
				hue[FW-1:0] = 16'((hsvrgb_pkg::ONE_Q16 * $urandom_range(0, 5)) / 6 +
					$urandom_range(0, 2) - 1);
			sat = rand_level();
			bri = rand_level();
			if ($urandom_range(0, 9) < 2) begin
				if ($urandom_range(0, 1))
					sat = SW'($urandom);
				else
					bri = SW'($urandom);
			end
			send_pixel(hue, sat, bri);
		end
	endtask

	// Hold the output off for a long stretch while input keeps coming
	task automatic test_backpressure();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		hold_req = 200;
		for (int i = 0; i < 60; i++)
			send_pixel($urandom, rand_level(), rand_level());
	endtask

	// Back-to-back transactions at one pixel per clock while the block is ready
	task automatic test_full_rate();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		for (int i = 0; i < 40; i++)
			send_pixel($urandom, rand_level(), rand_level());
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_traffic(680);
		test_backpressure();
		test_full_rate();
		s_tvalid <= 1'b0;
		while (rgb_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d pixels (%0d out of range), %0d results checked",
			pixels_sent, pixels_bad_range, results_checked);
		$display("input stalled for %0d cycles under output back-pressure", input_stalls);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/hsvrgb_pkg.sv
hdl/hsvrgb_front.sv
hdl/hsvrgb_mul.sv
hdl/hsvrgb_select.sv
hdl/hsv_to_rgb_converter_unit.sv
sim/tb_top.sv
